// ===== rtl/core/mwsm_pkg.sv =====
// mwsm_pkg: field widths and register indexes for the mecanum wheel speed mixer
// no dependencies; imported by mecanum_wheel_speed_mixer

package mwsm_pkg;

    // input command fields
    localparam int IN_W     = 16;
    localparam int IN_TDATA_W = 48;

    // configuration register widths
    localparam int ARM_W    = 12;
    localparam int GAIN_W   = 20;
    localparam int LIMIT_W  = 23;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_ROTATION_ARM = 2'd0;
    localparam cfg_addr_t REG_RPM_GAIN     = 2'd1;
    localparam cfg_addr_t REG_RPM_LIMIT    = 2'd2;

    // fixed-point intermediates
    localparam int ROT_PROD_W = ARM_W + 1 + IN_W;      // arm * yaw, signed
    localparam int ROT_SHIFT  = 10;
    localparam int ROT_W      = ROT_PROD_W - ROT_SHIFT;
    localparam int SUM_W      = ROT_W + 1;             // wheel sum, signed
    localparam int WPROD_W    = SUM_W + GAIN_W + 1;    // sum * gain, signed
    localparam int GAIN_SHIFT = 12;
    localparam int WSH_W      = WPROD_W - GAIN_SHIFT;  // after the floor shift
    localparam int WHEELS     = 4;

endpackage

// ===== rtl/core/mecanum_wheel_speed_mixer.sv =====
// mecanum_wheel_speed_mixer: pipelined inverse kinematics with wheel speed limiting
// depends on mwsm_pkg

// Takes one body velocity command per clock and returns four wheel speeds in 1/16 rpm
// plus a flag on tuser when the set was scaled down to the rpm limit. A result passes
// through 30 register stages after its command transfer: five arithmetic
// stages (rotation product, wheel sums, gain product, floor shift with saturation,
// largest magnitude), one stage for the limit product, then a 23-stage restoring
// divider that resolves one quotient bit per stage for all four wheels, and the output
// register. Throughput is one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall at the output holds every stage
// in place. Configuration writes take effect at once and are expected only while the
// pipeline is empty.

module mecanum_wheel_speed_mixer #(
    parameter int SPEED_WIDTH = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // forward_speed [15:0], sideways_speed [31:16], yaw_rate [47:32]
    input  logic [mwsm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // wheel speed output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // lf_speed, rf_speed, lr_speed, rr_speed, SPEED_WIDTH bits each, low first
    output logic [((4*SPEED_WIDTH+7)/8)*8-1:0] m_tdata,
    // limited [0]
    output logic                               m_tuser,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mwsm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mwsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mwsm_pkg::*;

    localparam int SW    = SPEED_WIDTH;
    localparam int OUT_W = ((4*SPEED_WIDTH+7)/8)*8;
    localparam int NW    = SW + LIMIT_W;      // mag * limit
    localparam int XW    = WSH_W + SW + 1;    // saturation compare width
    localparam int LW    = LIMIT_W;           // quotient bits / divider stages

    localparam logic signed [XW-1:0] SAT_HI = (XW'(1) <<< (SW-1)) - XW'(1);
    localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

    // configuration registers
    logic [ARM_W-1:0]   arm_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [LIMIT_W-1:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_reg   <= '0;
            gain_reg  <= '0;
            limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                REG_ROTATION_ARM: arm_reg   <= cfg_data[ARM_W-1:0];
                REG_RPM_GAIN:     gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_RPM_LIMIT:    limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // global advance: output register free or being taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic dv_reg [0:LW];
    logic out_valid_reg;

    // payload registers
    logic signed [IN_W-1:0]       fwd1_reg, side1_reg;
    logic signed [ROT_PROD_W-1:0] rprod1_reg;
    logic signed [SUM_W-1:0]      sum2_reg   [0:WHEELS-1];
    logic signed [WPROD_W-1:0]    wprod3_reg [0:WHEELS-1];
    logic signed [SW-1:0]         w4_reg     [0:WHEELS-1];
    logic [SW-1:0]                mag4_reg   [0:WHEELS-1];
    logic signed [SW-1:0]         w5_reg     [0:WHEELS-1];
    logic [SW-1:0]                mag5_reg   [0:WHEELS-1];
    logic [SW-1:0]                largest5_reg;
    logic                         lim5_reg;
    logic [NW-1:0]                rem_reg    [0:LW][0:WHEELS-1];
    logic [LW-1:0]                q_reg      [0:LW][0:WHEELS-1];
    logic signed [SW-1:0]         dw_reg     [0:LW][0:WHEELS-1];
    logic [SW-1:0]                dlargest_reg [0:LW];
    logic                         dlim_reg   [0:LW];
    logic signed [SW-1:0]         out_speed_reg [0:WHEELS-1];
    logic                         out_lim_reg;

    // next values
    logic signed [ROT_PROD_W-1:0] rprod1_next;
    logic signed [SUM_W-1:0]      sum2_next   [0:WHEELS-1];
    logic signed [WPROD_W-1:0]    wprod3_next [0:WHEELS-1];
    logic signed [SW-1:0]         w4_next     [0:WHEELS-1];
    logic [SW-1:0]                mag4_next   [0:WHEELS-1];
    logic [SW-1:0]                largest5_next;
    logic                         lim5_next;
    logic [NW-1:0]                rem_next    [0:LW][0:WHEELS-1];
    logic [LW-1:0]                q_next      [0:LW][0:WHEELS-1];
    logic signed [SW-1:0]         out_speed_next [0:WHEELS-1];

    // stage 1: rotation product
    assign rprod1_next = $signed({1'b0, arm_reg}) * $signed(s_tdata[3*IN_W-1:2*IN_W]);

    // stage 2: rotation floor shift and wheel sums
    always_comb
    begin
        logic signed [ROT_W-1:0] rot;
        logic signed [SUM_W-1:0] f, s, r;
        rot = rprod1_reg[ROT_PROD_W-1:ROT_SHIFT];
        f   = SUM_W'(fwd1_reg);
        s   = SUM_W'(side1_reg);
        r   = SUM_W'(rot);
        sum2_next[0] = f - s - r;
        sum2_next[1] = f + s + r;
        sum2_next[2] = f + s - r;
        sum2_next[3] = f - s + r;
    end

    // stage 3: gain products
    always_comb
    begin
        for (int i = 0; i < WHEELS; i++)
            wprod3_next[i] = sum2_reg[i] * $signed({1'b0, gain_reg});
    end

    // stage 4: floor shift, saturation and magnitude
    always_comb
    begin
        logic signed [XW-1:0] x;
        logic signed [SW-1:0] w;
        for (int i = 0; i < WHEELS; i++)
        begin
            x = XW'($signed(wprod3_reg[i][WPROD_W-1:GAIN_SHIFT]));
            if (x > SAT_HI)
                w = SAT_HI[SW-1:0];
            else if (x < SAT_LO)
                w = SAT_LO[SW-1:0];
            else
                w = x[SW-1:0];
            w4_next[i]   = w;
            mag4_next[i] = w[SW-1] ? -w : w;
        end
    end

    // stage 5: largest magnitude and limit decision
    always_comb
    begin
        logic [SW-1:0] m01, m23;
        m01 = (mag4_reg[0] > mag4_reg[1]) ? mag4_reg[0] : mag4_reg[1];
        m23 = (mag4_reg[2] > mag4_reg[3]) ? mag4_reg[2] : mag4_reg[3];
        largest5_next = (m01 > m23) ? m01 : m23;
        lim5_next = (limit_reg != '0) && (NW'(largest5_next) > NW'(limit_reg));
    end

    // divider entry: limit products, then one quotient bit per stage
    always_comb
    begin
        logic [NW-1:0] dvsr;
        for (int i = 0; i < WHEELS; i++)
        begin
            rem_next[0][i] = NW'(mag5_reg[i]) * NW'(limit_reg);
            q_next[0][i]   = '0;
        end
        for (int j = 1; j <= LW; j++)
        begin
            dvsr = NW'(dlargest_reg[j-1]) << (LW - j);
            for (int i = 0; i < WHEELS; i++)
            begin
                q_next[j][i] = q_reg[j-1][i];
                if (rem_reg[j-1][i] >= dvsr)
                begin
                    rem_next[j][i]       = rem_reg[j-1][i] - dvsr;
                    q_next[j][i][LW - j] = 1'b1;
                end
                else
                begin
                    rem_next[j][i] = rem_reg[j-1][i];
                end
            end
        end
    end

    // output: scaled or unscaled speeds
    always_comb
    begin
        logic [NW-1:0] qx;
        logic [SW-1:0] qs;
        for (int i = 0; i < WHEELS; i++)
        begin
            qx = NW'(q_reg[LW][i]);
            qs = qx[SW-1:0];
            if (dlim_reg[LW])
                out_speed_next[i] = dw_reg[LW][i][SW-1] ? -qs : qs;
            else
                out_speed_next[i] = dw_reg[LW][i];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int j = 0; j <= LW; j++)
                dv_reg[j] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
            for (int j = 1; j <= LW; j++)
                dv_reg[j] <= dv_reg[j-1];
            out_valid_reg <= dv_reg[LW];
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fwd1_reg     <= s_tdata[IN_W-1:0];
            side1_reg    <= s_tdata[2*IN_W-1:IN_W];
            rprod1_reg   <= rprod1_next;
            sum2_reg     <= sum2_next;
            wprod3_reg   <= wprod3_next;
            w4_reg       <= w4_next;
            mag4_reg     <= mag4_next;
            w5_reg       <= w4_reg;
            mag5_reg     <= mag4_reg;
            largest5_reg <= largest5_next;
            lim5_reg     <= lim5_next;
            rem_reg[0]      <= rem_next[0];
            q_reg[0]        <= q_next[0];
            dw_reg[0]       <= w5_reg;
            dlargest_reg[0] <= largest5_reg;
            dlim_reg[0]     <= lim5_reg;
            for (int j = 1; j <= LW; j++)
            begin
                rem_reg[j]      <= rem_next[j];
                q_reg[j]        <= q_next[j];
                dw_reg[j]       <= dw_reg[j-1];
                dlargest_reg[j] <= dlargest_reg[j-1];
                dlim_reg[j]     <= dlim_reg[j-1];
            end
            out_speed_reg <= out_speed_next;
            out_lim_reg   <= dlim_reg[LW];
        end
    end

    // output ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_lim_reg;
    assign m_tdata  = OUT_W'({out_speed_reg[3], out_speed_reg[2],
                              out_speed_reg[1], out_speed_reg[0]});

`ifndef SYNTHESIS
    // magnitudes of the outgoing speeds, for the limit check
    logic [SW-1:0] out_mag [0:WHEELS-1];
    always_comb
    begin
        for (int i = 0; i < WHEELS; i++)
            out_mag[i] = out_speed_reg[i][SW-1] ? -out_speed_reg[i] : out_speed_reg[i];
    end

    // a limited set never exceeds the limit
    a_limited_within: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            NW'(out_mag[0]) <= NW'(limit_reg) && NW'(out_mag[1]) <= NW'(limit_reg) &&
            NW'(out_mag[2]) <= NW'(limit_reg) && NW'(out_mag[3]) <= NW'(limit_reg))
        else $error("limited wheel speed above rpm limit");

    // limiting only happens with a nonzero limit
    a_limit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> limit_reg != '0)
        else $error("limited flag with limiting disabled");

    // a stalled pipeline keeps its divider contents
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_reg[LW]) && $stable(q_reg[LW][0]) && $stable(out_lim_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
